// ----- src/rlpe_pkg.sv -----
// ----------------------------------------------------------------------------
// rlpe_pkg
// Shared types and constants for the RGB LED pulse encoder.
// ----------------------------------------------------------------------------
package rlpe_pkg;

  localparam int unsigned DUTY_WIDTH_DEF = 16;
  localparam int unsigned BITS_PER_PIXEL = 24;
  localparam int unsigned NUM_CHAN       = 3;

  localparam logic [7:0]  BRIGHT_RST   = 8'd255;
  localparam logic [15:0] CODE_ONE_RST = 16'd75;
  localparam logic [15:0] CODE_ZERO_RST = 16'd35;
  localparam logic [15:0] RST_LEN_RST  = 16'd100;
  localparam logic [15:0] ROUND_BIAS   = 16'd127;

  typedef enum logic [1:0] {
    REG_BRIGHT    = 2'd0,
    REG_CODE_ONE  = 2'd1,
    REG_CODE_ZERO = 2'd2,
    REG_RST_LEN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] code_one;
    logic [15:0] code_zero;
    logic [15:0] rst_len;
  } enc_cfg_t;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

endpackage

// ----- src/rlpe_scale_lane.sv -----
// ----------------------------------------------------------------------------
// rlpe_scale_lane
// One colour lane: v*b registered, then rounded divide by 255 registered.
// ----------------------------------------------------------------------------
module rlpe_scale_lane import rlpe_pkg::*; (
  input  logic       clk,
  input  logic       ld_mul,
  input  logic       ld_div,
  input  logic [7:0] chan_in,
  input  logic [7:0] bright,
  output logic [7:0] chan_out
);

  logic [15:0] prod_r;
  logic [7:0]  quo_r;
  logic [16:0] x;
  logic [16:0] sum;

  // (x + (x >> 8) + 1) >> 8 equals x / 255 for x below 65536
  assign x   = {1'b0, prod_r} + {1'b0, ROUND_BIAS};
  assign sum = x + {8'd0, x[16:8]} + 17'd1;

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      prod_r <= chan_in * bright;
    end
    if (ld_div) begin
      quo_r <= sum[15:8];
    end
  end

  assign chan_out = quo_r;

endmodule

// ----- src/rlpe_serializer.sv -----
// ----------------------------------------------------------------------------
// rlpe_serializer
// Merges lane results into 24 duty words, MSB first; last pixels add the tail.
// ----------------------------------------------------------------------------
module rlpe_serializer import rlpe_pkg::*; #(
  parameter int unsigned DUTY_WIDTH = DUTY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        pix_valid,
  output logic        pix_take,
  input  pixel_t      pix,
  input  enc_cfg_t    cfg,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  localparam logic [15:0] DUTY_MASK = (DUTY_WIDTH >= 16) ? 16'hFFFF :
                                      16'((32'd1 << DUTY_WIDTH) - 32'd1);

  logic [23:0] sh_r, sh_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic        busy_r, busy_nxt;
  logic        tail_r, tail_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] od_r, od_nxt;
  logic        ou_r, ou_nxt;
  logic        ol_r, ol_nxt;
  logic        load;
  logic        fin;
  logic [15:0] code;

  assign load     = !ov_r || out_tready;
  assign fin      = (idx_r == 5'(BITS_PER_PIXEL - 1) && !tail_r) ||
                    (idx_r == 5'(BITS_PER_PIXEL));
  assign pix_take = pix_valid && (!busy_r || (load && fin));
  assign code     = (sh_r[23] ? cfg.code_one : cfg.code_zero) & DUTY_MASK;

  always_comb begin
    sh_nxt   = sh_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    tail_nxt = tail_r;
    ov_nxt   = ov_r;
    od_nxt   = od_r;
    ou_nxt   = ou_r;
    ol_nxt   = ol_r;
    if (load) begin
      ov_nxt = busy_r;
      if (busy_r) begin
        if (idx_r == 5'(BITS_PER_PIXEL)) begin
          od_nxt = {cfg.rst_len, 16'd0};
          ou_nxt = 1'b1;
        end else begin
          od_nxt = {16'd1, code};
          ou_nxt = 1'b0;
        end
        ol_nxt  = fin;
        sh_nxt  = {sh_r[22:0], 1'b0};
        idx_nxt = idx_r + 5'd1;
        if (fin) begin
          busy_nxt = 1'b0;
        end
      end
    end
    if (pix_take) begin
      sh_nxt   = {pix.green, pix.red, pix.blue};
      idx_nxt  = 5'd0;
      busy_nxt = 1'b1;
      tail_nxt = pix.last && (cfg.rst_len != 16'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
    sh_r   <= sh_nxt;
    idx_r  <= idx_nxt;
    tail_r <= tail_nxt;
    od_r   <= od_nxt;
    ou_r   <= ou_nxt;
    ol_r   <= ol_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tuser  = ou_r;
  assign out_tlast  = ol_r;

endmodule

// ----- src/rgb_led_pulse_encoder.sv -----
// ----------------------------------------------------------------------------
// rgb_led_pulse_encoder
// Scales a pixel by brightness in three lanes and emits its duty words.
//
//   port group | dir | contents
//   in_*       | in  | one pixel per word, tlast = last pixel of frame
//   out_*      | out | one duty word per slot, tuser = reset tail
//   cfg_*      | in  | APB registers: brightness, code one/zero, tail length
//
// A pixel gives 24 output words, 25 with the reset tail; the output register
// emits one word per cycle unless stalled, which sets the sustained rate.
// Input passes multiply, divide, load and output registers before output.
// The next pixel is taken as the last word of the current one is loaded.
// Synchronous reset clears valid/busy flags and loads register defaults.
// Output stalls hold the output word and back-pressure the lane pipeline.
// ----------------------------------------------------------------------------
module rgb_led_pulse_encoder import rlpe_pkg::*; #(
  parameter int unsigned DUTY_WIDTH = DUTY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // duty_code[15:0], repeat_count[31:16]
  output logic        out_tuser,  // is_tail
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]  bright_r;
  enc_cfg_t    cfg_r;
  logic        wr_en;
  reg_idx_t    widx;

  logic        v1_r, v2_r;
  logic        last1_r, last2_r;
  logic        rdy1, rdy2;
  logic        ld1, ld2;
  logic        pix_take;
  pixel_t      pix;
  logic [7:0]  scaled [NUM_CHAN];
  logic [7:0]  chan_in [NUM_CHAN];

  // configuration port
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign widx       = reg_idx_t'(cfg_paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r        <= BRIGHT_RST;
      cfg_r.code_one  <= CODE_ONE_RST;
      cfg_r.code_zero <= CODE_ZERO_RST;
      cfg_r.rst_len   <= RST_LEN_RST;
    end else if (wr_en) begin
      case (widx)
        REG_BRIGHT:    bright_r        <= cfg_pwdata[7:0];
        REG_CODE_ONE:  cfg_r.code_one  <= cfg_pwdata[15:0];
        REG_CODE_ZERO: cfg_r.code_zero <= cfg_pwdata[15:0];
        REG_RST_LEN:   cfg_r.rst_len   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_BRIGHT:    cfg_prdata = {24'd0, bright_r};
      REG_CODE_ONE:  cfg_prdata = {16'd0, cfg_r.code_one};
      REG_CODE_ZERO: cfg_prdata = {16'd0, cfg_r.code_zero};
      REG_RST_LEN:   cfg_prdata = {16'd0, cfg_r.rst_len};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // lane pipeline control
  assign rdy2      = !v2_r || pix_take;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;
  assign ld1       = in_tvalid && rdy1;
  assign ld2       = v1_r && rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
    end
    if (ld1) last1_r <= in_tlast;
    if (ld2) last2_r <= last1_r;
  end

  assign chan_in[0] = in_tdata[15:8];   // green
  assign chan_in[1] = in_tdata[7:0];    // red
  assign chan_in[2] = in_tdata[23:16];  // blue

  for (genvar i = 0; i < NUM_CHAN; i++) begin : g_lane
    rlpe_scale_lane u_lane (
      .clk     (clk),
      .ld_mul  (ld1),
      .ld_div  (ld2),
      .chan_in (chan_in[i]),
      .bright  (bright_r),
      .chan_out(scaled[i])
    );
  end

  assign pix.green = scaled[0];
  assign pix.red   = scaled[1];
  assign pix.blue  = scaled[2];
  assign pix.last  = last2_r;

  rlpe_serializer #(
    .DUTY_WIDTH(DUTY_WIDTH)
  ) u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (v2_r),
    .pix_take  (pix_take),
    .pix       (pix),
    .cfg       (cfg_r),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- verif/rlpe_checker.sv -----
// ----------------------------------------------------------------------------
// rlpe_checker
// Watches the pixel, duty and register buses of the pulse encoder. Every
// accepted pixel is expanded into the duty words it should produce. Every
// accepted duty word is compared against the oldest expected one.
// ----------------------------------------------------------------------------
module rlpe_checker import rlpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // duty_code[15:0], repeat_count[31:16]
  input  logic        out_tuser,  // is_tail
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] duty;
    logic [15:0] reps;
    logic        tail;
    logic        last;
  } slot_t;

  logic [7:0]  brightness;
  logic [15:0] code_one;
  logic [15:0] code_zero;
  logic [15:0] tail_len;
  slot_t       slot_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic [7:0] scale(input logic [7:0] v);
    int unsigned p;
    p = (int'(v) * int'(brightness) + 127) / 255;
    return p[7:0];
  endfunction

  task automatic queue_pixel(input logic [23:0] px, input logic last);
    logic [23:0] bits;
    logic        with_tail;
    slot_t       s;
    // green, red, blue; sent MSB first
    bits = {scale(px[15:8]), scale(px[7:0]), scale(px[23:16])};
    with_tail = last && (tail_len != 16'd0);
    for (int i = 23; i >= 0; i--) begin
      s.duty = bits[i] ? code_one : code_zero;
      s.reps = 16'd1;
      s.tail = 1'b0;
      s.last = (i == 0) && !with_tail;
      slot_q.push_back(s);
    end
    if (with_tail) begin
      s = '{duty: 16'd0, reps: tail_len, tail: 1'b1, last: 1'b1};
      slot_q.push_back(s);
    end
  endtask

  task automatic check_slot(input slot_t got);
    slot_t want;
    if (slot_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: unexpected word duty=%h reps=%h tail=%b last=%b", $realtime,
                 got.duty, got.reps, got.tail, got.last);
    end else begin
      want = slot_q.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: word mismatch exp duty=%h reps=%h tail=%b last=%b, %s%h %h %b %b",
                   $realtime, want.duty, want.reps, want.tail, want.last, "got ",
                   got.duty, got.reps, got.tail, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      brightness = BRIGHT_RST;
      code_one   = CODE_ONE_RST;
      code_zero  = CODE_ZERO_RST;
      tail_len   = RST_LEN_RST;
      slot_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_BRIGHT:    brightness = cfg_pwdata[7:0];
          REG_CODE_ONE:  code_one   = cfg_pwdata[15:0];
          REG_CODE_ZERO: code_zero  = cfg_pwdata[15:0];
          REG_RST_LEN:   tail_len   = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready)
        check_slot('{duty: out_tdata[15:0], reps: out_tdata[31:16],
                     tail: out_tuser, last: out_tlast});
      if (in_tvalid && in_tready)
        queue_pixel(in_tdata, in_tlast);
    end
    pending = slot_q.size();
  end

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives pixels and register writes into the pulse encoder under several
// sender/receiver idling mixes. The checker beside the block predicts and
// compares every duty word; this module only makes stimulus and the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import rlpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 600000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // duty_code[15:0], repeat_count[31:16]
  logic        out_tuser;  // is_tail
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  rgb_led_pulse_encoder DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  rlpe_checker u_checker (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata, .in_tlast,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fail_count, .pending
  );

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic set_regs(input logic [31:0] br, input logic [31:0] one,
                          input logic [31:0] zero, input logic [31:0] tlen);
    reg_write(REG_BRIGHT, br);
    reg_write(REG_CODE_ONE, one);
    reg_write(REG_CODE_ZERO, zero);
    reg_write(REG_RST_LEN, tlen);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [31:0] rand_tail_len();
    case ($urandom_range(5))
      0:       return {16'($urandom_range(65535)), 16'h0000};
      1:       return 32'h0000_FFFF;
      2:       return 32'd1;
      default: return {16'($urandom()), 16'($urandom_range(300))};
    endcase
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults: full brightness, tail of 100
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    send_pixel(8'h55, 8'hAA, 8'h0F, 1'b1);
    send_pixel(8'h01, 8'h80, 8'hFE, 1'b1);
    drain();

    // zero tail length: last pixel ends on its 24th word
    set_regs(32'hFFFF_FF00, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0000);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h80, 8'h7F, 8'h01, 1'b0);
    drain();

    set_regs(32'd1, 32'd0, 32'h0000_FFFF, 32'h1234_FFFF);
    send_pixel(8'hFF, 8'hFF, 8'h80, 1'b1);
    send_pixel(8'h7F, 8'hFE, 8'h01, 1'b0);
    send_pixel(8'hFF, 8'h00, 8'hFF, 1'b1);
    drain();

    set_regs(32'd128, 32'd1234, 32'd4321, 32'd1);
    send_pixel(8'hFF, 8'h01, 8'h02, 1'b1);
    send_pixel(8'h7F, 8'h80, 8'h81, 1'b0);
    send_pixel(8'hC3, 8'h3C, 8'h99, 1'b1);
    drain();

    set_regs(32'd254, 32'hFFFF_ABCD, 32'd0, 32'd65535);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 18; stall_pct = 18; end
      endcase
      set_regs(($urandom_range(3) == 0) ? {24'($urandom()), 8'hFF} : $urandom(),
               $urandom(), $urandom(), rand_tail_len());
      for (int k = 0; k < 40; k++) begin
        // hold off until the encoder has emptied once per phase
        if (k == 20) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        send_pixel(rand_chan(), rand_chan(), rand_chan(), $urandom_range(3) == 0);
      end
      @(negedge clk);
      in_tvalid <= 1'b0;
      drain();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
